// ===== rtl/gta_pkg.sv =====
// Shared constants and the digit step of the GF(2^128) multiplier for the GHASH tag engine.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps
package gta_pkg;

    localparam int BLOCK_W           = 128;
    localparam int HALF_W            = 64;
    localparam int COUNT_W           = 5;
    localparam int TOTAL_W           = 61;
    localparam int DIGIT_W           = 8;
    localparam int MUL_STEPS         = BLOCK_W / DIGIT_W;
    localparam int STEP_W            = $clog2(MUL_STEPS);
    localparam int TAG_BYTES_DEFAULT = 16;
    localparam int BLOCK_BYTES       = BLOCK_W / 8;
    localparam int S_TDATA_W         = 136;
    localparam int CFG_ADDR_W        = 2;

    localparam logic [7:0] GF_REDUCE_TOP = 8'he1;

    localparam logic [CFG_ADDR_W-1:0] REG_HASH_KEY_HI = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HASH_KEY_LO = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TAG_MASK_HI = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TAG_MASK_LO = 2'd3;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef struct packed {
        block_t z;
        block_t v;
    } mul_acc_t;

    // One digit of the reflected GF(2^128) multiply, leading operand bit first.
    function automatic mul_acc_t gf_mul_digit(mul_acc_t cur, logic [DIGIT_W-1:0] digit);
        mul_acc_t r;
        logic     lsb;
        r = cur;
        for (int k = 0; k < DIGIT_W; k++) begin
            if (digit[DIGIT_W-1-k]) begin
                r.z = r.z ^ r.v;
            end
            lsb = r.v[0];
            r.v = r.v >> 1;
            if (lsb) begin
                r.v[BLOCK_W-1 -: 8] = r.v[BLOCK_W-1 -: 8] ^ GF_REDUCE_TOP;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/ghash_tag_accumulator_top.sv =====
// GHASH tag engine: zero-pads and absorbs blocks, multiplies by H and emits the masked tag.
// Depends on gta_pkg for constants and the multiplier digit step.
// Each block with a non-zero count occupies the digit-serial multiplier while s_tready stays low.
// A closing item also runs the length block through the multiplier, then loads the tag when the output is free.
// A new block is not accepted until the multiplier, and any closing length block and tag load, is finished.
// Synchronous active-low reset clears the accumulator, byte totals, registers and handshakes.
`timescale 1ns / 1ps
module ghash_tag_accumulator_top
    import gta_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [HALF_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: data_hi[63:0], data_lo[63:0], byte_count[4:0], zero fill.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Bit 0: mode.
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: tag_hi[63:0], tag_lo[63:0].
    output logic [BLOCK_W-1:0]    m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam block_t TAG_MASK = ~({BLOCK_W{1'b1}} >> (8 * TAG_BYTES));

    logic [1:0]         state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               len_phase_reg;
    logic               last_pend_reg;
    block_t             acc_reg;
    block_t             x_reg;
    block_t             z_reg;
    block_t             v_reg;
    logic [TOTAL_W-1:0] aad_total_reg;
    logic [TOTAL_W-1:0] text_total_reg;
    logic [HALF_W-1:0]  key_hi_reg;
    logic [HALF_W-1:0]  key_lo_reg;
    logic [HALF_W-1:0]  mask_hi_reg;
    logic [HALF_W-1:0]  mask_lo_reg;
    logic               m_tvalid_reg;
    block_t             m_tdata_reg;

    mul_acc_t           mul_next;
    block_t             z_next;
    block_t             v_next;
    block_t             data_in;
    block_t             data_masked;
    logic [COUNT_W-1:0] count_raw;
    logic [COUNT_W-1:0] count_sat;
    logic [7:0]         pad_shift;
    block_t             len_block;
    block_t             len_block_after;
    logic [TOTAL_W-1:0] aad_total_next;
    logic [TOTAL_W-1:0] text_total_next;
    logic               in_xfer;
    logic               step_done;
    logic               tag_load;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_tdata_reg[HALF_W-1:0], m_tdata_reg[BLOCK_W-1:HALF_W]};
    assign step_done = (step_reg == STEP_W'(MUL_STEPS - 1));
    assign tag_load  = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    assign data_in   = {s_tdata[HALF_W-1:0], s_tdata[HALF_W +: HALF_W]};
    assign count_raw = s_tdata[BLOCK_W +: COUNT_W];
    assign count_sat = (count_raw > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : count_raw;
    assign pad_shift = {count_sat, 3'b000};
    assign data_masked = data_in & ~({BLOCK_W{1'b1}} >> pad_shift);

    assign len_block = {aad_total_reg, 3'b000, text_total_reg, 3'b000};

    always_comb begin
        aad_total_next  = aad_total_reg;
        text_total_next = text_total_reg;
        if (s_tuser) begin
            text_total_next = text_total_reg + TOTAL_W'(count_sat);
        end else begin
            aad_total_next = aad_total_reg + TOTAL_W'(count_sat);
        end
    end

    assign len_block_after = {aad_total_reg, 3'b000, text_total_reg, 3'b000};

    always_comb begin
        mul_next = gf_mul_digit('{z: z_reg, v: v_reg}, x_reg[BLOCK_W-1 -: DIGIT_W]);
        z_next   = mul_next.z;
        v_next   = mul_next.v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg  <= '0;
            key_lo_reg  <= '0;
            mask_hi_reg <= '0;
            mask_lo_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HASH_KEY_HI: key_hi_reg  <= cfg_wdata;
                REG_HASH_KEY_LO: key_lo_reg  <= cfg_wdata;
                REG_TAG_MASK_HI: mask_hi_reg <= cfg_wdata;
                REG_TAG_MASK_LO: mask_lo_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            len_phase_reg  <= 1'b0;
            last_pend_reg  <= 1'b0;
            acc_reg        <= '0;
            aad_total_reg  <= '0;
            text_total_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (tag_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (count_sat != '0) begin
                            x_reg          <= acc_reg ^ data_masked;
                            z_reg          <= '0;
                            v_reg          <= {key_hi_reg, key_lo_reg};
                            step_reg       <= '0;
                            len_phase_reg  <= 1'b0;
                            last_pend_reg  <= s_tlast;
                            aad_total_reg  <= aad_total_next;
                            text_total_reg <= text_total_next;
                            state_reg      <= ST_MUL;
                        end else if (s_tlast) begin
                            x_reg         <= acc_reg ^ len_block;
                            z_reg         <= '0;
                            v_reg         <= {key_hi_reg, key_lo_reg};
                            step_reg      <= '0;
                            len_phase_reg <= 1'b1;
                            last_pend_reg <= 1'b0;
                            state_reg     <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (!step_done) begin
                        z_reg    <= z_next;
                        v_reg    <= v_next;
                        x_reg    <= x_reg << DIGIT_W;
                        step_reg <= step_reg + STEP_W'(1);
                    end else begin
                        acc_reg <= z_next;
                        if (len_phase_reg) begin
                            state_reg <= ST_FIN;
                        end else if (last_pend_reg) begin
                            x_reg         <= z_next ^ len_block_after;
                            z_reg         <= '0;
                            v_reg         <= {key_hi_reg, key_lo_reg};
                            step_reg      <= '0;
                            len_phase_reg <= 1'b1;
                            last_pend_reg <= 1'b0;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FIN: begin
                    if (tag_load) begin
                        m_tdata_reg    <= (acc_reg ^ {mask_hi_reg, mask_lo_reg}) & TAG_MASK;
                        acc_reg        <= '0;
                        aad_total_reg  <= '0;
                        text_total_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/gta_checker.sv =====
// Port-level assertions for the GHASH tag engine and the bind that attaches them.
// Depends on gta_pkg and on the ports of ghash_tag_accumulator_top.
`timescale 1ns / 1ps
module gta_checker
    import gta_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [BLOCK_W-1:0]    m_tdata
);

    logic in_xfer;
    logic has_data;

    assign in_xfer  = s_tvalid && s_tready;
    assign has_data = (s_tdata[BLOCK_W +: COUNT_W] != '0);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed.");

    a_block_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && has_data |=> !s_tready)
        else $error("Input ready while a block is being multiplied.");

    a_no_early_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("Result appeared after a non-closing transfer.");

endmodule

bind ghash_tag_accumulator_top gta_checker u_gta_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for ghash_tag_accumulator_top: a directed table, then random messages.
// Tags are checked against a bit-serial GHASH predictor kept inside this bench, or a directed row's fixed tag.
// Depends on gta_pkg and the top-level RTL only.
`timescale 1ns / 1ps
module tb_top;
    import gta_pkg::*;

    localparam int TAG_BYTES    = TAG_BYTES_DEFAULT;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 10;
    localparam int PHASE_BLOCKS = 90;
    localparam int PLAN_LEN     = 28;

    typedef struct packed {
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  byte_count;
        logic        mode;
        logic        last;
    } gcm_block_t;

    typedef enum logic {ROW_BLOCK, ROW_REG} row_kind_t;

    // For register rows the value travels in data_hi.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [63:0]           data_hi;
        logic [63:0]           data_lo;
        logic [4:0]            byte_count;
        logic                  mode;
        logic                  last;
        logic                  fixed;
        logic [127:0]          fixed_tag;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0, 64'h0, 5'd0, 1'b0, 1'b1, 1'b1, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff,
          5'd16, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff,
          5'd31, 1'b1, 1'b1, 1'b1, 128'h0},
        '{ROW_REG, REG_TAG_MASK_HI, 64'hffffffffffffffff, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_REG, REG_TAG_MASK_LO, 64'h0123456789abcdef, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0, 64'h0, 5'd0, 1'b0, 1'b1, 1'b1,
          128'hffffffffffffffff0123456789abcdef},
        '{ROW_REG, REG_HASH_KEY_HI, 64'h66e94bd4ef8a2c3b, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_REG, REG_HASH_KEY_LO, 64'h884cfa59ca342b2e, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_REG, REG_TAG_MASK_HI, 64'h58e2fccefa7e3061, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_REG, REG_TAG_MASK_LO, 64'h367f1d57a4e7455a, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0388dace60b6a392, 64'hf328c2b971b2fe78,
          5'd16, 1'b1, 1'b1, 1'b1, 128'hab6e47d42cec13bdf53a67b21257bddf},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a,
          5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0123456789abcdef, 64'hfedcba9876543210,
          5'd1, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hdeadbeefcafef00d, 64'h1122334455667788,
          5'd7, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h8badf00d0badc0de, 64'h99aabbccddeeff00,
          5'd8, 1'b1, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h7766554433221100, 64'hf0e1d2c3b4a59687,
          5'd9, 1'b1, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0,
          5'd15, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h13579bdf2468ace0, 64'hfdb97531eca86420,
          5'd17, 1'b1, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hc3c3c3c3c3c3c3c3, 64'h3c3c3c3c3c3c3c3c,
          5'd12, 1'b1, 1'b1, 1'b0, 128'h0},
        '{ROW_REG, REG_HASH_KEY_HI, 64'hffffffffffffffff, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_REG, REG_HASH_KEY_LO, 64'hffffffffffffffff, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff,
          5'd16, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h8000000000000000, 64'h0000000000000001,
          5'd16, 1'b1, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 1'b0, 128'h0},
        '{ROW_REG, REG_TAG_MASK_LO, 64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0, 64'h0, 5'd16, 1'b0, 1'b1, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff,
          5'd31, 1'b0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, REG_HASH_KEY_HI, 64'h0, 64'h0, 5'd0, 1'b0, 1'b1, 1'b0, 128'h0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [HALF_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // From bit 0: data_hi[63:0], data_lo[63:0], byte_count[4:0], zero fill.
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // Bit 0: mode.
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // From bit 0: tag_hi[63:0], tag_lo[63:0].
    logic [BLOCK_W-1:0]    m_tdata;

    // Predictor state and the register copy it works from.
    logic [127:0] ghash_acc;
    logic [60:0]  aad_total;
    logic [60:0]  text_total;
    logic [127:0] hash_key;
    logic [127:0] tag_mask;

    logic [127:0] tag_queue [$];
    int           mismatches  = 0;
    int           tags_seen   = 0;
    int           blocks_sent = 0;
    int           settings    = 0;
    int           cycles      = 0;
    int           stall_style = 0;
    int           stall_left  = 0;
    int           burst_left  = 0;
    bit           offering    = 1'b0;

    ghash_tag_accumulator_top #(
        .TAG_BYTES (TAG_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [127:0] lead_bytes(int n);
        if (n == 0) begin
            return '0;
        end
        return ~128'b0 << (128 - 8 * n);
    endfunction

    // Reflected GF(2^128) product, the leading bit of x taken first.
    function automatic logic [127:0] gf_times(logic [127:0] x, logic [127:0] y);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = y;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) begin
                z = z ^ v;
            end
            carry = v[0];
            v = v >> 1;
            if (carry) begin
                v[127:120] = v[127:120] ^ GF_REDUCE_TOP;
            end
        end
        return z;
    endfunction

    // Advances the predictor by one block; returns 1 when the block closes a message.
    function automatic bit predict_tag(input gcm_block_t b, output logic [127:0] tag);
        int n;
        n   = (b.byte_count > 5'd16) ? 16 : int'(b.byte_count);
        tag = '0;
        if (n != 0) begin
            ghash_acc = gf_times(ghash_acc ^ ({b.data_hi, b.data_lo} & lead_bytes(n)), hash_key);
            if (b.mode) begin
                text_total = text_total + 61'(n);
            end else begin
                aad_total = aad_total + 61'(n);
            end
        end
        if (!b.last) begin
            return 1'b0;
        end
        ghash_acc = gf_times(ghash_acc ^ {aad_total, 3'b000, text_total, 3'b000}, hash_key);
        tag = (ghash_acc ^ tag_mask) & lead_bytes(TAG_BYTES);
        ghash_acc  = '0;
        aad_total  = '0;
        text_total = '0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_HASH_KEY_HI: hash_key[127:64] = value;
            REG_HASH_KEY_LO: hash_key[63:0]   = value;
            REG_TAG_MASK_HI: tag_mask[127:64] = value;
            REG_TAG_MASK_LO: tag_mask[63:0]   = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Drops tvalid, waits for every tag, then lets the multiplier finish any open block.
    task automatic settle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (tag_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_block(input gcm_block_t b, input bit fixed,
                               input logic [127:0] fixed_tag);
        logic [127:0] tag;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, b.byte_count, b.data_lo, b.data_hi};
        s_tuser  <= b.mode;
        s_tlast  <= b.last;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (predict_tag(b, tag)) begin
            tag_queue.push_back(fixed ? fixed_tag : tag);
        end
        if (b.byte_count != 5'd0 || b.last) begin
            blocks_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(5, 40);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            tags_seen++;
            if (tag_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected tag transfer, expected none, got %h", $time, m_tdata);
            end else begin
                want = tag_queue.pop_front();
                if (m_tdata[63:0] !== want[127:64]) begin
                    mismatches++;
                    $display("%0t: tag_hi mismatch, expected %h, got %h",
                             $time, want[127:64], m_tdata[63:0]);
                end
                if (m_tdata[127:64] !== want[63:0]) begin
                    mismatches++;
                    $display("%0t: tag_lo mismatch, expected %h, got %h",
                             $time, want[63:0], m_tdata[127:64]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d tags outstanding",
                     cycles, tag_queue.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        gcm_block_t b;
        logic [63:0] value;
        int          phase_blocks;
        int          msg_len;
        int          split;
        bit          noisy;
        int          pick;

        ghash_acc  = '0;
        aad_total  = '0;
        text_total = '0;
        hash_key   = '0;
        tag_mask   = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (PLAN[r]) begin
            if (PLAN[r].kind == ROW_REG) begin
                settle();
                write_reg(PLAN[r].reg_idx, PLAN[r].data_hi);
            end else begin
                b.data_hi    = PLAN[r].data_hi;
                b.data_lo    = PLAN[r].data_lo;
                b.byte_count = PLAN[r].byte_count;
                b.mode       = PLAN[r].mode;
                b.last       = PLAN[r].last;
                offer_block(b, PLAN[r].fixed, PLAN[r].fixed_tag);
            end
        end
        settings++;

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            stall_style = ph % 3;
            for (int idx = 0; idx < 4; idx++) begin
                pick = $urandom_range(0, 5);
                value = (pick == 0) ? 64'h0 :
                        (pick == 1) ? ~64'h0 : {$urandom, $urandom};
                write_reg(CFG_ADDR_W'(idx), value);
            end
            settings++;
            phase_blocks = 0;
            while (phase_blocks < PHASE_BLOCKS) begin
                msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 14)
                                                      : $urandom_range(1, 6);
                split   = $urandom_range(0, msg_len);
                noisy   = ($urandom_range(0, 7) == 0);
                for (int j = 0; j < msg_len; j++) begin
                    pick = $urandom_range(0, 9);
                    b.data_hi    = {$urandom, $urandom};
                    b.data_lo    = {$urandom, $urandom};
                    b.byte_count = (pick < 6) ? 5'd16 :
                                   (pick < 8) ? 5'($urandom_range(1, 15)) :
                                   (pick == 8) ? 5'($urandom_range(17, 31)) : 5'd0;
                    if (noisy) begin
                        b.mode = 1'($urandom_range(0, 1));
                        b.last = ($urandom_range(0, 3) == 0);
                    end else begin
                        b.mode = (j >= split);
                        b.last = (j == msg_len - 1);
                    end
                    offer_block(b, 1'b0, '0);
                    if (b.byte_count != 5'd0 || b.last) begin
                        phase_blocks++;
                    end
                end
            end
        end

        settle();
        $display("Sent %0d blocks over %0d register settings; %0d tags checked, %0d mismatches.",
                 blocks_sent, settings, tags_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
